### hdl/bgu_pkg.sv
// Shared constants and types of the bilinear 2x grid upscaler.
package bgu_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W   = 11;
    localparam int ELEV_W  = 24;
    localparam int VALUE_W = 26;
    localparam int COORD_W = 11;

    typedef logic signed [ELEV_W-1:0]  elev_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [CFG_W-1:0]          cfg_data_t;

    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_index_t;

endpackage

### hdl/bgu_in_if.sv
// Input channel of the upscaler: one source elevation sample per beat.
interface bgu_in_if;
    logic           valid;
    logic           ready;
    bgu_pkg::elev_t elevation;

    modport source (output valid, output elevation, input ready);
    modport sink   (input valid, input elevation, output ready);
endinterface

### hdl/bgu_out_if.sv
// Output channel of the upscaler: one upsampled grid point per beat.
interface bgu_out_if;
    logic            valid;
    logic            ready;
    bgu_pkg::coord_t out_row;
    bgu_pkg::coord_t out_col;
    bgu_pkg::value_t value;
    logic            last_of_item;
    logic            end_of_grid;

    modport source (output valid, output out_row, output out_col, output value,
                    output last_of_item, output end_of_grid, input ready);
    modport sink   (input valid, input out_row, input out_col, input value,
                    input last_of_item, input end_of_grid, output ready);
endinterface

### hdl/bilinear_2x_grid_upscaler.sv
// A sample goes through stage 1, stage 2 and the output register; stalls can hold it.
// A sample at row r, column c yields 1 + (r>0) + (c>0) + (r>0 and c>0) results,
// up to 4, that leave one a beat; stage 1 can take the next sample meanwhile.
// Reset clears the grid position, the neighbor registers and all valid flags and
// sets both grid dimensions to 1024; the row memory is left as it is.
module bilinear_2x_grid_upscaler #(
    parameter int MAX_WIDTH  = bgu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bgu_pkg::DEF_MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  bgu_pkg::reg_index_t cfg_index,
    input  bgu_pkg::cfg_data_t  cfg_data,
    bgu_in_if.sink              samples,
    bgu_out_if.source           results
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    // Common compare width for positions against the configured dimensions.
    localparam int DW = ((CW > RW) ? ((CW > bgu_pkg::CFG_W) ? CW : bgu_pkg::CFG_W)
                                   : ((RW > bgu_pkg::CFG_W) ? RW : bgu_pkg::CFG_W)) + 1;
    localparam int CFG_MAX = (1 << bgu_pkg::CFG_W) - 1;
    localparam bgu_pkg::cfg_data_t W_CLIP =
        bgu_pkg::CFG_W'((MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH);
    localparam bgu_pkg::cfg_data_t H_CLIP =
        bgu_pkg::CFG_W'((MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT);

    // Bit positions of the pending-result mask, in the order results leave.
    localparam int RES_QUAD  = 0;
    localparam int RES_VERT  = 1;
    localparam int RES_HORIZ = 2;
    localparam int RES_COPY  = 3;

    // ------------------------------------------------------------------
    // Configuration and grid position.
    // ------------------------------------------------------------------
    bgu_pkg::cfg_data_t width_reg, width_next;
    bgu_pkg::cfg_data_t height_reg, height_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    bgu_pkg::cfg_data_t w_eff;
    bgu_pkg::cfg_data_t h_eff;
    logic               col_last;
    logic               row_last;
    logic               accept;

    // A dimension of zero counts as one, and one above the maximum saturates.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = bgu_pkg::CFG_W'(1);
        else if (width_reg > W_CLIP)
            w_eff = W_CLIP;
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = bgu_pkg::CFG_W'(1);
        else if (height_reg > H_CLIP)
            h_eff = H_CLIP;
        else
            h_eff = height_reg;
    end

    assign col_last = (DW'(col_reg) + DW'(1)) >= DW'(w_eff);
    assign row_last = (DW'(row_reg) + DW'(1)) >= DW'(h_eff);

    // A register write also restarts the grid at its first sample.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bgu_pkg::REG_GRID_WIDTH:  width_next  = cfg_data;
                bgu_pkg::REG_GRID_HEIGHT: height_next = cfg_data;
                default:                  width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bgu_pkg::CFG_W'(1024);
            height_reg <= bgu_pkg::CFG_W'(1024);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control.
    // Stage 1 holds a sample while the row memory reads the sample above it.
    // Stage 2 holds the full neighborhood and hands out one result per beat.
    // ------------------------------------------------------------------
    logic          p1_valid_reg;
    logic [3:0]    s2_mask_reg, s2_mask_next;
    logic          out_valid_reg;
    logic          out_free;
    logic          s2_fire;
    logic          s2_done;
    logic          p1_move;

    assign out_free = !out_valid_reg || results.ready;
    assign s2_fire  = (s2_mask_reg != '0) && out_free;
    // The copy result always goes last, so the item is done once it alone remains.
    assign s2_done  = s2_fire && (s2_mask_reg[RES_HORIZ:RES_QUAD] == '0);
    assign p1_move  = p1_valid_reg && ((s2_mask_reg == '0) || s2_done);

    assign samples.ready = !p1_valid_reg || p1_move;
    assign accept        = samples.valid && samples.ready;

    // ------------------------------------------------------------------
    // Row memory: the previous source row, one entry per column.
    // The entry for this column is read and overwritten at the same edge;
    // the read returns the old contents, which is the sample one row above.
    // The next read of that entry comes a full row later, or one beat later
    // when the grid is one column wide, so no forwarding is needed.
    // ------------------------------------------------------------------
    bgu_pkg::elev_t row_store [MAX_WIDTH];
    bgu_pkg::elev_t up_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg          <= row_store[col_reg];
            row_store[col_reg] <= samples.elevation;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sample, its left neighbor and its position.
    // ------------------------------------------------------------------
    bgu_pkg::elev_t left_reg;
    bgu_pkg::elev_t p1_s_reg;
    bgu_pkg::elev_t p1_left_reg;
    logic [CW-1:0]  p1_c_reg;
    logic [RW-1:0]  p1_r_reg;
    logic           p1_end_reg;
    bgu_pkg::elev_t p1_up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            if (accept)
                p1_valid_reg <= 1'b1;
            else if (p1_move)
                p1_valid_reg <= 1'b0;
            if (accept)
                left_reg <= samples.elevation;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_s_reg    <= samples.elevation;
            p1_left_reg <= left_reg;
            p1_c_reg    <= col_reg;
            p1_r_reg    <= row_reg;
            p1_end_reg  <= row_last && col_last;
        end
    end

    // The top row has nothing above it; its entries may not be written yet.
    assign p1_up = (p1_r_reg != '0) ? up_rd_reg : '0;

    // ------------------------------------------------------------------
    // Stage 2: the whole 2x2 neighborhood and the results still owed.
    // ------------------------------------------------------------------
    bgu_pkg::elev_t ul_reg;
    bgu_pkg::elev_t s2_s_reg;
    bgu_pkg::elev_t s2_left_reg;
    bgu_pkg::elev_t s2_up_reg;
    bgu_pkg::elev_t s2_ul_reg;
    logic [CW-1:0]  s2_c_reg;
    logic [RW-1:0]  s2_r_reg;
    logic           s2_end_reg;
    logic [3:0]     p1_mask;

    assign p1_mask[RES_QUAD]  = (p1_r_reg != '0) && (p1_c_reg != '0);
    assign p1_mask[RES_VERT]  = (p1_r_reg != '0);
    assign p1_mask[RES_HORIZ] = (p1_c_reg != '0);
    assign p1_mask[RES_COPY]  = 1'b1;

    // Clear the bit of the result that leaves now, and take the next item.
    always_comb
    begin
        s2_mask_next = s2_mask_reg;
        if (s2_fire)
        begin
            if (s2_mask_reg[RES_QUAD])
                s2_mask_next[RES_QUAD] = 1'b0;
            else if (s2_mask_reg[RES_VERT])
                s2_mask_next[RES_VERT] = 1'b0;
            else if (s2_mask_reg[RES_HORIZ])
                s2_mask_next[RES_HORIZ] = 1'b0;
            else
                s2_mask_next[RES_COPY] = 1'b0;
        end
        if (p1_move)
            s2_mask_next = p1_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_mask_reg <= '0;
            ul_reg      <= '0;
        end
        else
        begin
            s2_mask_reg <= s2_mask_next;
            if (p1_move)
                ul_reg <= p1_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_move)
        begin
            s2_s_reg    <= p1_s_reg;
            s2_left_reg <= p1_left_reg;
            s2_up_reg   <= p1_up;
            s2_ul_reg   <= ul_reg;
            s2_c_reg    <= p1_c_reg;
            s2_r_reg    <= p1_r_reg;
            s2_end_reg  <= p1_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result selection. Q16.8 in and Q16.10 out keep every result exact:
    // a copy is times four, a pair sum times two, a four-point sum as is.
    // ------------------------------------------------------------------
    bgu_pkg::coord_t row_even, row_odd, col_even, col_odd;
    bgu_pkg::value_t v_quad, v_vert, v_horiz, v_copy;
    bgu_pkg::coord_t sel_row, sel_col;
    bgu_pkg::value_t sel_value;
    logic            sel_last;

    assign row_even = bgu_pkg::COORD_W'({s2_r_reg, 1'b0});
    assign col_even = bgu_pkg::COORD_W'({s2_c_reg, 1'b0});
    assign row_odd  = row_even - bgu_pkg::COORD_W'(1);
    assign col_odd  = col_even - bgu_pkg::COORD_W'(1);

    assign v_quad  = bgu_pkg::VALUE_W'(s2_s_reg) + bgu_pkg::VALUE_W'(s2_left_reg)
                   + bgu_pkg::VALUE_W'(s2_up_reg) + bgu_pkg::VALUE_W'(s2_ul_reg);
    assign v_vert  = (bgu_pkg::VALUE_W'(s2_s_reg) + bgu_pkg::VALUE_W'(s2_up_reg)) <<< 1;
    assign v_horiz = (bgu_pkg::VALUE_W'(s2_s_reg) + bgu_pkg::VALUE_W'(s2_left_reg)) <<< 1;
    assign v_copy  = bgu_pkg::VALUE_W'(s2_s_reg) <<< 2;

    always_comb
    begin
        sel_last = 1'b0;
        if (s2_mask_reg[RES_QUAD])
        begin
            sel_row   = row_odd;
            sel_col   = col_odd;
            sel_value = v_quad;
        end
        else if (s2_mask_reg[RES_VERT])
        begin
            sel_row   = row_odd;
            sel_col   = col_even;
            sel_value = v_vert;
        end
        else if (s2_mask_reg[RES_HORIZ])
        begin
            sel_row   = row_even;
            sel_col   = col_odd;
            sel_value = v_horiz;
        end
        else
        begin
            sel_row   = row_even;
            sel_col   = col_even;
            sel_value = v_copy;
            sel_last  = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a result until the sink takes the beat.
    // ------------------------------------------------------------------
    bgu_pkg::coord_t out_row_reg;
    bgu_pkg::coord_t out_col_reg;
    bgu_pkg::value_t out_value_reg;
    logic            out_last_reg;
    logic            out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_fire;
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_row_reg   <= sel_row;
            out_col_reg   <= sel_col;
            out_value_reg <= sel_value;
            out_last_reg  <= sel_last;
            out_end_reg   <= sel_last && s2_end_reg;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.out_row      = out_row_reg;
    assign results.out_col      = out_col_reg;
    assign results.value        = out_value_reg;
    assign results.last_of_item = out_last_reg;
    assign results.end_of_grid  = out_end_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Every item still in stage 2 owes its copy result.
    a_copy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_mask_reg != '0) |-> s2_mask_reg[RES_COPY])
        else $error("stage 2 holds results without the closing copy");

    // The end of the grid can only mark the closing result of a sample.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.end_of_grid) |-> results.last_of_item)
        else $error("end of grid on a result that does not close its sample");

    // The copy of a source sample always lands on even coordinates.
    a_copy_even: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.last_of_item)
            |-> (!results.out_row[0] && !results.out_col[0]))
        else $error("copy result at an odd coordinate");

    // A stage 1 item that cannot move keeps its position.
    a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && !p1_move) |=> (p1_valid_reg && $stable(p1_c_reg)
            && $stable(p1_r_reg)))
        else $error("stage 1 item lost or changed while stalled");

endmodule

### bench/testbench.sv
// Self-checking bench for the bilinear 2x grid upscaler: directed plan plus random grids.
module testbench;

    localparam int MAX_W        = bgu_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H        = bgu_pkg::DEF_MAX_HEIGHT;
    localparam bgu_pkg::elev_t  ELEV_MAX = 24'sh7FFFFF;
    localparam bgu_pkg::elev_t  ELEV_MIN = 24'sh800000;
    localparam bgu_pkg::value_t V_TOP    = 26'sh1FFFFFC;
    localparam bgu_pkg::value_t V_BOT    = 26'sh2000000;
    localparam bgu_pkg::value_t V_ZERO   = 26'sd0;
    localparam bgu_pkg::reg_index_t IDX_W = bgu_pkg::REG_GRID_WIDTH;
    localparam bgu_pkg::reg_index_t IDX_H = bgu_pkg::REG_GRID_HEIGHT;
    localparam int RANDOM_BEATS = 270;
    localparam int CALM_FROM    = 220;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PLAN_ROWS    = 24;

    // One upsampled grid point as it leaves the block.
    typedef struct packed {
        bgu_pkg::coord_t row;
        bgu_pkg::coord_t col;
        bgu_pkg::value_t value;
        logic            last;
        logic            eog;
    } grid_point_t;

    // One step of the directed plan: either a register write or a sample.
    // Where typed is set, want is the single point the sample must yield.
    typedef struct {
        bit                  is_write;
        bgu_pkg::reg_index_t idx;
        bgu_pkg::cfg_data_t  data;
        bgu_pkg::elev_t      elev;
        bit                  typed;
        grid_point_t         want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    bgu_pkg::reg_index_t cfg_index;
    bgu_pkg::cfg_data_t cfg_data;

    bgu_in_if  samples();
    bgu_out_if results();

    bilinear_2x_grid_upscaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .results   (results)
    );

    // Points the block still owes, oldest first, and the ones the last sample produced.
    grid_point_t pending_points[$];
    grid_point_t fresh_points[$];

    // Shadow of the block: grid dimensions as written, the row above, the two
    // neighbor samples and the position of the next source sample.
    bgu_pkg::cfg_data_t shadow_width  = bgu_pkg::cfg_data_t'(1024);
    bgu_pkg::cfg_data_t shadow_height = bgu_pkg::cfg_data_t'(1024);
    int          row_above[MAX_W];
    int          left_elev     = 0;
    int          upper_left    = 0;
    int unsigned next_col      = 0;
    int unsigned next_row      = 0;

    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          stall_left    = 0;
    bit          idling_on     = 1'b1;

    // Directed plan. It opens at the reset dimensions, then shrinks the grid to a
    // single point through zero writes, runs a 2x2 grid at both extremes of the
    // sample range (so the four-neighbor sum hits both ends of the value field),
    // wraps past the end of the grid, restarts it part way through, and
    // finally saturates both dimensions with all-ones writes.
    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b1, '{11'd0, 11'd0, V_TOP,  1'b1, 1'b0}},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    24'h5A5A5A, 1'b0, '0},
        '{1'b1, IDX_W, 11'd0,    24'h0,      1'b0, '0},
        '{1'b1, IDX_H, 11'd0,    24'h0,      1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b1, '{11'd0, 11'd0, V_TOP,  1'b1, 1'b1}},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b1, '{11'd0, 11'd0, V_BOT,  1'b1, 1'b1}},
        '{1'b1, IDX_W, 11'd2,    24'h0,      1'b0, '0},
        '{1'b1, IDX_H, 11'd2,    24'h0,      1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b1, '{11'd0, 11'd0, V_TOP,  1'b1, 1'b0}},
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b1, '{11'd0, 11'd0, V_BOT,  1'b1, 1'b0}},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    24'h0,      1'b1, '{11'd0, 11'd0, V_ZERO, 1'b1, 1'b0}},
        '{1'b0, IDX_W, 11'd0,    24'h1,      1'b0, '0},
        '{1'b1, IDX_W, 11'd2047, 24'h0,      1'b0, '0},
        '{1'b1, IDX_H, 11'd2047, 24'h0,      1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    ELEV_MIN,   1'b1, '{11'd0, 11'd0, V_BOT,  1'b1, 1'b0}},
        '{1'b0, IDX_W, 11'd0,    ELEV_MAX,   1'b0, '0},
        '{1'b0, IDX_W, 11'd0,    24'h123456, 1'b0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Works out every point that one source sample yields, in the order the block
    // sends them, and advances the shadow position. Results are exact: a copy is
    // the sample times four, a two-point average is the pair sum times two, and a
    // four-point average is the plain sum of the four samples.
    function automatic void upsample_sample(input bgu_pkg::elev_t s);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int          sv;
        int          up;
        logic        eog;
        w = (shadow_width == 0) ? 1 : ((shadow_width > MAX_W) ? MAX_W : shadow_width);
        h = (shadow_height == 0) ? 1 : ((shadow_height > MAX_H) ? MAX_H : shadow_height);
        r = (next_row >= h) ? h - 1 : next_row;
        c = (next_col >= w) ? w - 1 : next_col;
        eog = (r == h - 1) && (c == w - 1);
        sv = s;
        up = (r > 0) ? row_above[c] : 0;
        fresh_points.delete();
        if (r > 0 && c > 0)
            fresh_points.push_back('{bgu_pkg::coord_t'(2 * r - 1), bgu_pkg::coord_t'(2 * c - 1),
                                     bgu_pkg::value_t'(sv + left_elev + up + upper_left),
                                     1'b0, 1'b0});
        if (r > 0)
            fresh_points.push_back('{bgu_pkg::coord_t'(2 * r - 1), bgu_pkg::coord_t'(2 * c),
                                     bgu_pkg::value_t'((sv + up) * 2), 1'b0, 1'b0});
        if (c > 0)
            fresh_points.push_back('{bgu_pkg::coord_t'(2 * r), bgu_pkg::coord_t'(2 * c - 1),
                                     bgu_pkg::value_t'((sv + left_elev) * 2), 1'b0, 1'b0});
        fresh_points.push_back('{bgu_pkg::coord_t'(2 * r), bgu_pkg::coord_t'(2 * c),
                                 bgu_pkg::value_t'(sv * 4), 1'b1, eog});
        row_above[c] = sv;
        upper_left = up;
        left_elev = sv;
        if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    // Presents one sample and holds it until the block takes it. Valid is left
    // high so that a following sample goes out without a gap.
    task automatic drive_sample(input bgu_pkg::elev_t e, input bit typed,
                                input grid_point_t want);
        samples.valid     <= 1'b1;
        samples.elevation <= e;
        do
            @(posedge clk);
        while (!samples.ready);
        upsample_sample(e);
        if (typed)
            pending_points.push_back(want);
        else
            foreach (fresh_points[i])
                pending_points.push_back(fresh_points[i]);
    endtask

    // Sender gap: lowers valid for a stretch whose length the caller gives.
    task automatic hold_off(input int cycles);
        samples.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Lowers valid and waits until the block has handed over every point it owes.
    task automatic drain_points();
        samples.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
    endtask

    // Register writes happen only with the block drained. A write also sends the
    // grid back to its first source position. The write enable is a one-cycle
    // strobe, so back-to-back writes never drive it twice in one step.
    task automatic write_register(input bgu_pkg::reg_index_t idx,
                                  input bgu_pkg::cfg_data_t data);
        drain_points();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == bgu_pkg::REG_GRID_WIDTH)
            shadow_width = data;
        else
            shadow_height = data;
        next_col = 0;
        next_row = 0;
    endtask

    // A random sample: mostly uniform over the field, sometimes pinned to an end.
    function automatic bgu_pkg::elev_t random_elevation();
        case ($urandom_range(0, 9))
            0: return ELEV_MAX;
            1: return ELEV_MIN;
            default: return bgu_pkg::elev_t'($urandom);
        endcase
    endfunction

    // Receiver: ready drops for bursts of random length while idling is allowed.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            results.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left    <= $urandom_range(0, 10);
            results.ready <= 1'b0;
        end
        else
        begin
            results.ready <= 1'b1;
        end
    end

    // Every beat on the result channel is matched against the oldest owed point.
    always @(posedge clk)
    begin
        grid_point_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected result row %0d col %0d value %0d last %0b end %0b",
                         $time, results.out_row, results.out_col, results.value,
                         results.last_of_item, results.end_of_grid);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (results.out_row !== want.row || results.out_col !== want.col ||
                    results.value !== want.value || results.last_of_item !== want.last ||
                    results.end_of_grid !== want.eog)
                begin
                    $display("%0t: mismatch: expected row %0d col %0d value %0d last %0b end %0b",
                             $time, want.row, want.col, want.value, want.last, want.eog);
                    $display("%0t:           actual row %0d col %0d value %0d last %0b end %0b",
                             $time, results.out_row, results.out_col, results.value,
                             results.last_of_item, results.end_of_grid);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a long stretch without a beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples.valid && samples.ready) || (results.valid && results.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int          random_count;
        int          burst;
        int          mode;
        int unsigned w;
        int unsigned h;

        cfg_write         = 1'b0;
        cfg_index         = bgu_pkg::REG_GRID_WIDTH;
        cfg_data          = '0;
        samples.valid     = 1'b0;
        samples.elevation = '0;
        rst_n             = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan, with sender gaps sprinkled in between the beats.
        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_register(plan[i].idx, plan[i].data);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 11));
                drive_sample(plan[i].elev, plan[i].typed, plan[i].want);
            end
        end

        // Random grids. Most are small, so rows, wraps and end-of-grid come often;
        // now and then the dimensions take any 11-bit value and only the start of
        // the grid is run, and sometimes a single register is rewritten to restart
        // the grid part way through.
        random_count = 0;
        while (random_count < RANDOM_BEATS)
        begin
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                write_register(bgu_pkg::REG_GRID_WIDTH, bgu_pkg::cfg_data_t'($urandom));
                write_register(bgu_pkg::REG_GRID_HEIGHT, bgu_pkg::cfg_data_t'($urandom));
                burst = $urandom_range(4, 16);
            end
            else if (mode == 1)
            begin
                write_register(bgu_pkg::reg_index_t'($urandom_range(0, 1)),
                               bgu_pkg::cfg_data_t'($urandom_range(1, 8)));
                burst = $urandom_range(3, 30);
            end
            else
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                write_register(bgu_pkg::REG_GRID_WIDTH, bgu_pkg::cfg_data_t'(w));
                write_register(bgu_pkg::REG_GRID_HEIGHT, bgu_pkg::cfg_data_t'(h));
                burst = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
            end
            for (int k = 0; k < burst && random_count < RANDOM_BEATS; k++)
            begin
                // Idling comes and goes in windows and stops for the final stretch.
                idling_on = (random_count < CALM_FROM) && ((random_count / 30) % 3 != 2);
                if (idling_on && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 11));
                else if ($urandom_range(0, 49) == 0)
                    drain_points();
                drive_sample(random_elevation(), 1'b0, '0);
                random_count++;
            end
        end

        // Wait for every owed point, then a short tail to catch stray beats.
        drain_points();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### sim.f
hdl/bgu_pkg.sv
hdl/bgu_in_if.sv
hdl/bgu_out_if.sv
hdl/bilinear_2x_grid_upscaler.sv
bench/testbench.sv
